/* src/whc_pkg.sv */
//------------------------------------------------------------------------------
// whc_pkg
// Shared types, constants and helper functions of the word histogram block.
//------------------------------------------------------------------------------
`default_nettype none
package whc_pkg;
	localparam int unsigned DictSizeDefault = 1024;
	localparam int unsigned QueueDepth = 2;

	localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX1     = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX2     = 64'h94D049BB133111EB;
	localparam logic [63:0] POS_MUL  = 64'hD1B54A32D192ED03;
	localparam logic [63:0] FNV_INIT = 64'hCBF29CE484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

	localparam logic [1:0] FUNC_COUNT = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_SETPOS = 2'd2;

	localparam logic [1:0] REG_SEED  = 2'd0;
	localparam logic [1:0] REG_TOTAL = 2'd1;
	localparam logic [1:0] REG_INTV  = 2'd2;

	// Multiplication by the FNV prime (2^40 + 0x1B3) as shift and narrow multiply.
	function automatic logic [63:0] fnv_mul(input logic [63:0] h);
		logic [63:0] lo;
		lo = h * 64'h1B3;
		return lo + {h[23:0], 40'd0};
	endfunction

	// Classified request handed from the front part to the back part.
	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  word_id;
		logic [63:0] count_value;
		logic [63:0] position;
	} req_t;

	typedef struct packed {
		logic [63:0] epoch_number;
		logic [63:0] fingerprint;
		logic [63:0] words_done;
		logic        final_flag;
		logic        last_of_run;
	} res_t;
endpackage
`default_nettype wire

/* src/whc_if.sv */
//------------------------------------------------------------------------------
// whc_in_if / whc_out_if
// Valid-ready channels for requests and result events.
//------------------------------------------------------------------------------
`default_nettype none
interface whc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [9:0]  word_id;
	logic [63:0] count_value;
	logic [63:0] position;
	modport source (output valid, func, word_id, count_value, position, input ready);
	modport sink (input valid, func, word_id, count_value, position, output ready);
endinterface

interface whc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] epoch_number;
	logic [63:0] fingerprint;
	logic [63:0] words_done;
	logic        final_flag;
	logic        last_of_run;
	modport source (output valid, epoch_number, fingerprint, words_done, final_flag,
		last_of_run, input ready);
	modport sink (input valid, epoch_number, fingerprint, words_done, final_flag,
		last_of_run, output ready);
endinterface
`default_nettype wire

/* src/whc_ram.sv */
//------------------------------------------------------------------------------
// whc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module whc_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output      logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* src/whc_front.sv */
//------------------------------------------------------------------------------
// whc_front
// Accepts requests, drops unused codes and queues them for the back part.
//------------------------------------------------------------------------------
`default_nettype none
module whc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	whc_in_if.sink             in_ch,
	output      whc_pkg::req_t q_req,
	output      logic          q_valid,
	input  wire logic          q_pop
);
	import whc_pkg::*;

	req_t       buf_q [QueueDepth];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;
	req_t       req;

	assign in_ch.ready = (cnt_q != 2'(QueueDepth));
	assign req = '{func: in_ch.func, word_id: in_ch.word_id,
		count_value: in_ch.count_value, position: in_ch.position};
	// The unused code is accepted and discarded here.
	assign push = in_ch.valid && in_ch.ready && (in_ch.func != 2'd3);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = buf_q[rd_q];

	// Two-entry queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= req;
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QueueDepth))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count slip");
endmodule
`default_nettype wire

/* src/whc_back.sv */
//------------------------------------------------------------------------------
// whc_back
// Executes queued requests: word id hashing, count update and digest walks.
//------------------------------------------------------------------------------
`default_nettype none
module whc_back #(
	parameter int unsigned DictSize = whc_pkg::DictSizeDefault
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire whc_pkg::req_t q_req,
	input  wire logic          q_valid,
	output      logic          q_pop,
	input  wire logic [63:0]   seed,
	input  wire logic [63:0]   word_total,
	input  wire logic [31:0]   interval,
	whc_out_if.source          out_ch
);
	import whc_pkg::*;
	localparam int unsigned AW = $clog2(DictSize);

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_MUL, S_H0, S_H1, S_H2, S_H3, S_RD, S_WR,
		S_EV, S_WALK, S_WALK2, S_OUT
	} state_t;

	// Which constant the shared multiplier is working with.
	typedef enum logic [1:0] {
		P_POS, P_MIX1, P_MIX2
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic [1:0]  mstep_q;
	logic [AW:0] idx_q;
	logic [63:0] z_q, pos_q, epoch_q, h_q, cnt_q, prod_q;
	logic [31:0] since_q;
	logic [AW-1:0] w_q;
	logic        fin_q, two_q, second_q;
	res_t        res_q;
	logic        ovalid_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [64:0]   wdata, rdata;
	logic [31:0]   every;
	logic [63:0]   pos_inc;
	logic [AW-1:0] ia;
	logic [63:0]   mul_b64;
	logic [31:0]   mul_a, mul_b;
	logic [63:0]   mul_p, mul_sum;

	// Each entry holds the present mark above the 64-bit count.
	whc_ram #(.Width(65), .Depth(DictSize)) u_counts (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

	assign every = (interval == 32'd0) ? 32'd1 : interval;
	assign pos_inc = pos_q + 64'd1;
	assign ia = idx_q[AW-1:0];
	assign raddr = (state_q == S_H3 || state_q == S_RD) ? w_q : ia;

	// A 64-bit product modulo 2^64 built from three 32x32 partial products,
	// one per cycle: low by low, then the two cross terms shifted up.
	always_comb begin
		case (phase_q)
			P_POS:   mul_b64 = POS_MUL;
			P_MIX1:  mul_b64 = MIX1;
			default: mul_b64 = MIX2;
		endcase
	end
	assign mul_a = (mstep_q == 2'd2) ? z_q[63:32] : z_q[31:0];
	assign mul_b = (mstep_q == 2'd1) ? mul_b64[63:32] : mul_b64[31:0];
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
	assign mul_sum = prod_q + {mul_p[31:0], 32'd0};

	// Memory write: clearing pass, load, and count increment.
	always_comb begin
		we = 1'b0;
		waddr = w_q;
		wdata = {1'b1, rdata[63:0] + 64'd1};
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = ia;
			wdata = '0;
		end else if (state_q == S_IDLE && q_valid && q_req.func == FUNC_LOAD
				&& 32'(q_req.word_id) < DictSize) begin
			we = 1'b1;
			waddr = AW'(q_req.word_id);
			wdata = {1'b1, q_req.count_value};
		end else if (state_q == S_WR) begin
			we = 1'b1;
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_ch.valid = ovalid_q;
	assign out_ch.epoch_number = res_q.epoch_number;
	assign out_ch.fingerprint = res_q.fingerprint;
	assign out_ch.words_done = res_q.words_done;
	assign out_ch.final_flag = res_q.final_flag;
	assign out_ch.last_of_run = res_q.last_of_run;

	// Sequencer with registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= P_POS;
			mstep_q <= 2'd0;
			idx_q <= '0;
			pos_q <= '0;
			epoch_q <= '0;
			since_q <= '0;
			ovalid_q <= 1'b0;
			fin_q <= 1'b0;
			two_q <= 1'b0;
			second_q <= 1'b0;
			z_q <= '0;
			prod_q <= '0;
			h_q <= '0;
			cnt_q <= '0;
			w_q <= '0;
			res_q <= '0;
		end else begin
			if (ovalid_q && out_ch.ready && state_q != S_OUT) ovalid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (32'(idx_q) == DictSize - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						case (q_req.func)
							FUNC_SETPOS: begin
								pos_q <= q_req.position;
								since_q <= '0;
							end
							FUNC_COUNT: begin
								if (pos_q < word_total) begin
									z_q <= pos_q;
									phase_q <= P_POS;
									mstep_q <= 2'd0;
									state_q <= S_MUL;
								end else begin
									fin_q <= 1'b1;
									two_q <= 1'b0;
									second_q <= 1'b0;
									state_q <= S_EV;
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL: begin
					if (mstep_q == 2'd0) begin
						prod_q <= mul_p;
						mstep_q <= 2'd1;
					end else if (mstep_q == 2'd1) begin
						prod_q <= mul_sum;
						mstep_q <= 2'd2;
					end else begin
						mstep_q <= 2'd0;
						case (phase_q)
							P_POS: begin
								z_q <= seed ^ mul_sum;
								state_q <= S_H0;
							end
							P_MIX1: begin
								z_q <= mul_sum;
								state_q <= S_H2;
							end
							default: begin
								z_q <= mul_sum;
								state_q <= S_H3;
							end
						endcase
					end
				end
				S_H0: begin
					z_q <= z_q + GOLDEN;
					state_q <= S_H1;
				end
				S_H1: begin
					z_q <= z_q ^ (z_q >> 30);
					phase_q <= P_MIX1;
					state_q <= S_MUL;
				end
				S_H2: begin
					z_q <= z_q ^ (z_q >> 27);
					phase_q <= P_MIX2;
					state_q <= S_MUL;
				end
				S_H3: begin
					w_q <= AW'((z_q ^ (z_q >> 31)) % 64'(DictSize));
					state_q <= S_RD;
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					pos_q <= pos_inc;
					second_q <= 1'b0;
					if (since_q + 32'd1 >= every) begin
						fin_q <= 1'b0;
						two_q <= !(pos_inc < word_total);
						since_q <= '0;
						state_q <= S_EV;
					end else if (!(pos_inc < word_total)) begin
						fin_q <= 1'b1;
						two_q <= 1'b0;
						since_q <= '0;
						state_q <= S_EV;
					end else begin
						since_q <= since_q + 32'd1;
						state_q <= S_IDLE;
					end
				end
				S_EV: begin
					epoch_q <= epoch_q + 64'd1;
					h_q <= FNV_INIT;
					idx_q <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					// Read data for ia arrives next cycle; the id half of the
					// digest step does not need it.
					cnt_q <= fnv_mul(h_q ^ 64'(ia));
					state_q <= S_WALK2;
				end
				S_WALK2: begin
					if (rdata[64])
						h_q <= fnv_mul(cnt_q ^ rdata[63:0]);
					if (32'(idx_q) == DictSize - 1) begin
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_WALK;
					end
				end
				S_OUT: begin
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q <= 1'b1;
						res_q <= '{epoch_number: epoch_q, fingerprint: h_q,
							words_done: pos_q, final_flag: fin_q,
							last_of_run: !two_q};
						since_q <= '0;
						if (two_q) begin
							two_q <= 1'b0;
							fin_q <= 1'b1;
							second_q <= 1'b1;
							state_q <= S_EV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ch.ready) |=> ovalid_q)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV) |=> epoch_q == $past(epoch_q) + 64'd1)
		else $error("epoch not advanced");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE)
		else $error("pop while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(second_q && state_q == S_OUT) |-> fin_q)
		else $error("second event not final");
endmodule
`default_nettype wire

/* src/word_histogram_checkpoint.sv */
// A count request below the word total runs three 64-bit products built from
// 32x32 partial products, the xor-shift steps, then a count read-modify-write
// in the RAM. Load and set-position complete in the idle state. Each emitted
// event walks the whole table. After reset a clearing pass zeroes the count
// RAM; no request is executed during it. A two-entry queue separates front
// and back.
//------------------------------------------------------------------------------
// word_histogram_checkpoint
// Top level: configuration registers, front part, back part.
//------------------------------------------------------------------------------
`default_nettype none
module word_histogram_checkpoint #(
	parameter int unsigned DictSize = whc_pkg::DictSizeDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output      logic [63:0] prdata,
	output      logic        pready,
	whc_in_if.sink           in_ch,
	whc_out_if.source        out_ch
);
	import whc_pkg::*;

	logic [63:0] seed_q, total_q;
	logic [31:0] intv_q;
	req_t        q_req;
	logic        q_valid, q_pop;
	logic [1:0]  ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:3];

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			total_q <= '0;
			intv_q <= 32'd1;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_SEED:  seed_q <= pwdata;
				REG_TOTAL: total_q <= pwdata;
				REG_INTV:  intv_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (ridx)
			REG_SEED:  prdata = seed_q;
			REG_TOTAL: prdata = total_q;
			REG_INTV:  prdata = {32'd0, intv_q};
			default:   prdata = '0;
		endcase
	end

	whc_front u_front (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_req(q_req), .q_valid(q_valid), .q_pop(q_pop));

	whc_back #(.DictSize(DictSize)) u_back (.clk(clk), .arst_n(arst_n),
		.q_req(q_req), .q_valid(q_valid), .q_pop(q_pop), .seed(seed_q),
		.word_total(total_q), .interval(intv_q), .out_ch(out_ch));
endmodule
`default_nettype wire

/* sim/whc_checker.sv */
//------------------------------------------------------------------------------
// whc_checker
// Watches the configuration port and both channels of the word histogram
// block. It keeps its own copy of the histogram, predicts each checkpoint and
// final event, and compares every result with the oldest expected event.
//------------------------------------------------------------------------------
`default_nettype none
module whc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	whc_in_if                in_ch,
	whc_out_if               out_ch,
	output int unsigned      mismatches,
	output int unsigned      outstanding
);
	import whc_pkg::*;

	localparam int unsigned Words = 1024;

	// Shadow copy of the configuration and the histogram state.
	logic [63:0] mdl_seed;
	logic [63:0] mdl_total;
	logic [31:0] mdl_interval;
	logic [63:0] hist_count [Words];
	bit          hist_seen [Words];
	logic [63:0] next_pos;
	logic [63:0] epoch;
	logic [31:0] since_cp;

	res_t expected_events [$];

	// Word id of a corpus position: position mix, one splitmix64 step, modulo.
	function automatic logic [9:0] corpus_word(input logic [63:0] pos);
		logic [63:0] z;
		z = mdl_seed ^ (pos * POS_MUL);
		z = z + GOLDEN;
		z = (z ^ (z >> 30)) * MIX1;
		z = (z ^ (z >> 27)) * MIX2;
		z = z ^ (z >> 31);
		return z[9:0];
	endfunction

	// Digest over the present entries in ascending id order.
	function automatic logic [63:0] table_digest();
		logic [63:0] h;
		h = FNV_INIT;
		for (int i = 0; i < Words; i++) begin
			if (hist_seen[i]) begin
				h = (h ^ 64'(i)) * FNV_PRIME;
				h = (h ^ hist_count[i]) * FNV_PRIME;
			end
		end
		return h;
	endfunction

	task automatic add_event(input logic is_final, input logic is_last);
		res_t ev;
		epoch = epoch + 64'd1;
		ev.epoch_number = epoch;
		ev.fingerprint  = table_digest();
		ev.words_done   = next_pos;
		ev.final_flag   = is_final;
		ev.last_of_run  = is_last;
		expected_events = {expected_events, ev};
	endtask

	// Applies one accepted request to the shadow state.
	task automatic apply_request(input logic [1:0] fn, input logic [9:0] id,
			input logic [63:0] cnt, input logic [63:0] pos);
		logic [31:0] every;
		logic [9:0]  w;
		logic        at_end;
		case (fn)
			FUNC_LOAD: begin
				hist_count[id] = cnt;
				hist_seen[id]  = 1'b1;
			end
			FUNC_SETPOS: begin
				next_pos = pos;
				since_cp = '0;
			end
			FUNC_COUNT: begin
				if (next_pos < mdl_total) begin
					every = (mdl_interval == 0) ? 32'd1 : mdl_interval;
					w = corpus_word(next_pos);
					hist_count[w] = hist_count[w] + 64'd1;
					hist_seen[w]  = 1'b1;
					next_pos = next_pos + 64'd1;
					since_cp = since_cp + 32'd1;
					at_end = !(next_pos < mdl_total);
					if (since_cp >= every) begin
						add_event(1'b0, !at_end);
						since_cp = '0;
					end
					if (at_end) begin
						add_event(1'b1, 1'b1);
						since_cp = '0;
					end
				end else begin
					add_event(1'b1, 1'b1);
					since_cp = '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic report(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h, got %h", what, want, got);
	endtask

	// Compares results, then records requests and register writes.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			mdl_seed     = '0;
			mdl_total    = '0;
			mdl_interval = 32'd1;
			for (int i = 0; i < Words; i++) begin
				hist_count[i] = '0;
				hist_seen[i]  = 1'b0;
			end
			next_pos = '0;
			epoch    = '0;
			since_cp = '0;
			expected_events.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_events.size() == 0) begin
					report("unexpected event epoch", '0, out_ch.epoch_number);
				end else begin
					want = expected_events.pop_front();
					if (want.epoch_number !== out_ch.epoch_number)
						report("epoch_number", want.epoch_number, out_ch.epoch_number);
					if (want.fingerprint !== out_ch.fingerprint)
						report("fingerprint", want.fingerprint, out_ch.fingerprint);
					if (want.words_done !== out_ch.words_done)
						report("words_done", want.words_done, out_ch.words_done);
					if (want.final_flag !== out_ch.final_flag)
						report("final_flag", 64'(want.final_flag), 64'(out_ch.final_flag));
					if (want.last_of_run !== out_ch.last_of_run)
						report("last_of_run", 64'(want.last_of_run), 64'(out_ch.last_of_run));
				end
			end
			if (in_ch.valid && in_ch.ready)
				apply_request(in_ch.func, in_ch.word_id, in_ch.count_value, in_ch.position);
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_SEED:  mdl_seed = pwdata;
					REG_TOTAL: mdl_total = pwdata;
					REG_INTV:  mdl_interval = pwdata[31:0];
					default: begin
					end
				endcase
			end
			outstanding <= expected_events.size();
		end
	end
endmodule
`default_nettype wire

/* sim/tb.sv */
//------------------------------------------------------------------------------
// tb
// Stimulus and verdict for the word histogram block. Runs several register
// settings, each with a directed or random mix of count, load, set-position
// and unused requests, random idling on both channels; a checker judges them.
//------------------------------------------------------------------------------
`default_nettype none
module tb;
	import whc_pkg::*;

	localparam int unsigned CycleLimit = 30_000_000;
	localparam int unsigned PhaseItems = 280;
	localparam int unsigned Phases = 6;
	localparam logic [3:0] FUNC_SPARE = 4'd3;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	bit          calm;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned sent;
	int unsigned cycles;
	logic [63:0] cfg_total;

	whc_in_if  in_ch ();
	whc_out_if out_ch ();

	word_histogram_checkpoint i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source)
	);

	whc_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Clock with a period of four units.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard limit on the run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// The result side stalls at random outside the calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	// A 64-bit value, biased toward the extremes.
	function automatic logic [63:0] wide_value();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 64'($urandom_range(20));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Hands one request over; valid stays high afterwards until lowered.
	task automatic send_req(input logic [1:0] fn, input logic [9:0] id,
			input logic [63:0] cnt, input logic [63:0] pos);
		while (!calm && $urandom_range(99) < 35) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.func        <= fn;
		in_ch.word_id     <= id;
		in_ch.count_value <= cnt;
		in_ch.position    <= pos;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
		calm = (sent >= 500 && sent < 800);
	endtask

	// Lowers valid and waits until every expected event has come.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// A resume position near the end of the run, or anywhere.
	function automatic logic [63:0] resume_pos();
		case ($urandom_range(5))
			0: return '0;
			1: return cfg_total;
			2: return '1;
			3: return {$urandom, $urandom};
			default: return cfg_total - 64'($urandom_range(12));
		endcase
	endfunction

	task automatic random_req();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 58)
			send_req(FUNC_COUNT, 10'($urandom), 64'($urandom), 64'($urandom));
		else if (pick < 82)
			send_req(FUNC_LOAD, 10'($urandom), wide_value(), 64'($urandom));
		else if (pick < 96)
			send_req(FUNC_SETPOS, 10'($urandom), 64'($urandom), resume_pos());
		else
			send_req(FUNC_SPARE[1:0], 10'($urandom), wide_value(), wide_value());
	endtask

	initial begin
		logic [63:0] seeds [Phases];
		logic [63:0] totals [Phases];
		logic [31:0] intervals [Phases];
		seeds     = '{64'h0, '1, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}};
		totals    = '{64'd40, 64'd300, '1, 64'd0, 64'd200, 64'd150};
		intervals = '{32'd3, 32'd0, 32'd5, 32'd1, '1, 32'd7};

		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.func        <= FUNC_COUNT;
		in_ch.word_id     <= '0;
		in_ch.count_value <= '0;
		in_ch.position    <= '0;
		calm = 1'b0;
		sent = 0;
		cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < Phases; p++) begin
			// Registers change only once the block has gone quiet.
			drain();
			repeat (64) @(posedge clk);
			cfg_total = totals[p];
			reg_write(REG_SEED, seeds[p]);
			reg_write(REG_TOTAL, totals[p]);
			reg_write(REG_INTV, {32'd0, intervals[p]});

			if (p == 0) begin
				// Zero-count load, extreme ids and counts, checkpoint and end cases.
				send_req(FUNC_LOAD, 10'd0, 64'd0, '0);
				send_req(FUNC_LOAD, 10'd1023, '1, '1);
				send_req(FUNC_LOAD, 10'd512, 64'd1, '0);
				repeat (4) send_req(FUNC_COUNT, '1, '1, '1);
				send_req(FUNC_SPARE[1:0], '1, '1, '1);
				send_req(FUNC_SETPOS, '0, '0, 64'd38);
				send_req(FUNC_COUNT, '0, '0, '0);
				send_req(FUNC_COUNT, '0, '0, '0);
				send_req(FUNC_COUNT, '0, '0, '0);
				send_req(FUNC_SETPOS, '0, '0, 64'd37);
				repeat (3) send_req(FUNC_COUNT, '0, '0, '0);
				send_req(FUNC_SETPOS, '1, '1, '1);
				send_req(FUNC_COUNT, '0, '0, '0);
				send_req(FUNC_SETPOS, '0, '0, '0);
				repeat (3) send_req(FUNC_COUNT, '0, '0, '0);
			end

			for (int n = 0; n < PhaseItems; n++) begin
				// Once, the sender holds off until the block has caught up.
				if (p == 2 && n == 100) drain();
				random_req();
			end
		end

		drain();
		repeat (3000) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
